// ===== design/assert_macros.svh =====
// Assertion macros shared by the sparse register file RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SPRF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// When trig holds, prop must hold at the next edge.
`define SPRF_ASSERT_NEXT(name, clk, rst, trig, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/sprf_pkg.sv =====
// Shared types and constants for the sparse register file.
// No dependencies; imported by every module of the block but sprf_ram.
`timescale 1ns / 1ps

package sprf_pkg;

   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;

   // Access kinds
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Request word
   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] write_value;
   } sprf_req_type;

   // Response word
   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              status;
   } sprf_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture request, restart the scan
      logic issue;   // read the next filled entry
      logic commit;  // apply the write and load the response
   } sprf_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic more;      // filled entries left to read
      logic pending;   // a read is in flight to the comparator
      logic found;     // a matching entry has been captured
      logic rsp_free;  // response register can take a word this cycle
   } sprf_stat_type;

endpackage

// ===== design/sparse_register_file.sv =====
// sparse_register_file: associative store of up to ENTRIES address/value
// pairs. A write updates the entry holding its address or claims the next
// free entry (status 1 and nothing stored when all are taken); a read
// returns the stored value, or zero on a miss. Entries fill in order and
// are never removed, so a fill count stands in for per-entry valid bits.
// Each access walks the filled entries of the single-port-read entry RAM,
// one per cycle, stopping at the first match. The write and the response are
// committed after the scan, once the response register can take a word.
// The next word is accepted while a finished response still waits.
// Uses sprf_pkg.
`timescale 1ns / 1ps

module sparse_register_file
   import sprf_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sprf_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sprf_rsp_type rsp_word
);

   sprf_cmd_type  cmd;
   sprf_stat_type stat;

   sprf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sprf_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== design/sprf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the entry store of the sparse register file.
`timescale 1ns / 1ps

module sprf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sprf_datapath.sv =====
// Datapath of the sparse register file: entry RAM, fill count, scan
// pointer, comparator, hit capture and response register. Uses sprf_pkg, sprf_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sprf_datapath
   import sprf_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  sprf_req_type  req_word,
   input  sprf_cmd_type  cmd,
   output sprf_stat_type stat,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output sprf_rsp_type  rsp_word
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = ADDR_W + DATA_W;

   // Request hold
   sprf_req_type      req_ff;
   // Fill count: entries [0, count) are valid, the rest are free
   logic [CW-1:0]     count_ff, count_in;
   // Scan pointer and compare stage
   logic [CW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     cmp_idx_ff;
   logic              cmp_vld_ff;
   // Captured hit
   logic              found_ff, found_in;
   logic [IW-1:0]     found_idx_ff;
   logic [DATA_W-1:0] found_val_ff;
   // Response register
   logic              rsp_vld_ff, rsp_vld_in;
   sprf_rsp_type      rsp_ff, rsp_in;

   logic [EW-1:0]     ram_rdata;
   logic              hit_now;
   logic              full;
   logic              is_write;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;

   sprf_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_ff.addr, req_ff.write_value}),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   // Compare and commit decode
   assign hit_now  = cmp_vld_ff && (ram_rdata[EW-1:DATA_W] == req_ff.addr);
   assign full     = (count_ff == CW'(ENTRIES));
   assign is_write = (req_ff.req_type == REQ_WRITE);
   assign wr_en    = cmd.commit && is_write && (found_ff || !full);
   assign wr_addr  = found_ff ? found_idx_ff : count_ff[IW-1:0];

   // Next-state logic
   always_comb begin
      count_in = count_ff;
      if (cmd.commit && is_write && !found_ff && !full) begin
         count_in = count_ff + CW'(1);
      end

      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.issue) begin
         idx_in = idx_ff + CW'(1);
      end

      found_in = found_ff;
      if (cmd.load) begin
         found_in = 1'b0;
      end else if (hit_now) begin
         found_in = 1'b1;
      end

      rsp_in = rsp_ff;
      if (cmd.commit) begin
         rsp_in.read_value = '0;
         rsp_in.status     = STATUS_OK;
         if (is_write) begin
            if (!found_ff && full) begin
               rsp_in.status = STATUS_FULL;
            end
         end else if (found_ff) begin
            rsp_in.read_value = found_val_ff;
         end
      end

      rsp_vld_in = rsp_vld_ff;
      if (cmd.commit) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         cmp_vld_ff <= cmd.issue;
         found_ff   <= found_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.issue) begin
         cmp_idx_ff <= idx_ff[IW-1:0];
      end
      // first hit in scan order is the lowest-numbered match
      if (hit_now && !found_ff) begin
         found_idx_ff <= cmp_idx_ff;
         found_val_ff <= ram_rdata[DATA_W-1:0];
      end
      rsp_ff <= rsp_in;
   end

   // Status to controller
   assign stat.more     = (idx_ff < count_ff);
   assign stat.pending  = cmp_vld_ff;
   assign stat.found    = found_ff;
   assign stat.rsp_free = !rsp_vld_ff || !rsp_stall;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

   `SPRF_ASSERT(a_count_range, clock, reset, count_ff <= CW'(ENTRIES),
      "fill count beyond table size")
   `SPRF_ASSERT(a_found_filled, clock, reset,
      !found_ff || ({1'b0, found_idx_ff} < (IW+1)'(count_ff)),
      "captured hit outside filled entries")
   `SPRF_ASSERT_NEXT(a_claim_grows, clock, reset,
      cmd.commit && is_write && !found_ff && !full,
      count_ff == $past(count_ff) + CW'(1),
      "new entry claimed without count step")

endmodule

// ===== design/sprf_ctrl.sv =====
// Controller of the sparse register file: sequences accept, scan and
// commit of one access. Uses sprf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sprf_ctrl
   import sprf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  sprf_stat_type stat,
   output sprf_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      scan_done;

   // Scan ends on a captured hit or once every filled entry was compared
   assign scan_done = stat.found || (!stat.more && !stat.pending);

   // Commands
   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.issue  = (state_ff == ST_SCAN) && stat.more && !stat.found;
      cmd.commit = (state_ff == ST_FINISH) && stat.rsp_free;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SPRF_ASSERT(a_load_clean, clock, reset, !cmd.load || !stat.pending,
      "new access while a compare is still in flight")
   `SPRF_ASSERT_NEXT(a_pending_src, clock, reset, !cmd.issue, !stat.pending,
      "compare stage valid without a read")
   `SPRF_ASSERT_NEXT(a_finish_hold, clock, reset,
      (state_ff == ST_FINISH) && !stat.rsp_free, state_ff == ST_FINISH,
      "access dropped while response register busy")

endmodule

// ===== tb/sparse_register_file_tb.sv =====
// Self-checking bench for sparse_register_file: random and directed accesses
// checked against a behavioral copy of the associative store.
// Depends on sprf_pkg and the sparse_register_file RTL.
`timescale 1ns / 1ps

module sparse_register_file_tb;
   import sprf_pkg::*;

   localparam int SLOTS        = 128;
   localparam int HOLD_CYCLES  = 400;             // long receiver hold-off
   localparam int DRAIN_CYCLES = 2 * SLOTS + 40;
   localparam int IDLE_LIMIT   = 20000;

   // Tracks the store contents and the replies still owed by the block
   class access_scoreboard;
      bit                slot_used [SLOTS];
      logic [ADDR_W-1:0] slot_key  [SLOTS];
      logic [DATA_W-1:0] slot_data [SLOTS];
      sprf_rsp_type      awaited_replies [$];
      int unsigned       errors;

      function new();
         for (int s = 0; s < SLOTS; s++) slot_used[s] = 1'b0;
         errors = 0;
      endfunction

      // Lowest-numbered filled entry that holds key, or -1
      function int match_slot(logic [ADDR_W-1:0] key);
         for (int s = 0; s < SLOTS; s++)
            if (slot_used[s] && slot_key[s] == key) return s;
         return -1;
      endfunction

      function int first_empty_slot();
         for (int s = 0; s < SLOTS; s++)
            if (!slot_used[s]) return s;
         return -1;
      endfunction

      function int outstanding();
         return awaited_replies.size();
      endfunction

      // Apply one accepted access to the store and queue the reply it owes
      function void note_access(sprf_req_type w);
         sprf_rsp_type reply;
         int           s;
         reply.read_value = '0;
         reply.status     = STATUS_OK;
         s = match_slot(w.addr);
         if (w.req_type == REQ_WRITE) begin
            if (s >= 0) begin
               slot_data[s] = w.write_value;
            end else begin
               s = first_empty_slot();
               if (s >= 0) begin
                  slot_used[s] = 1'b1;
                  slot_key[s]  = w.addr;
                  slot_data[s] = w.write_value;
               end else begin
                  reply.status = STATUS_FULL;
               end
            end
         end else if (s >= 0) begin
            reply.read_value = slot_data[s];
         end
         awaited_replies.push_back(reply);
      endfunction

      function void check_reply(sprf_rsp_type got);
         sprf_rsp_type want;
         if (awaited_replies.size() == 0) begin
            $error("reply word with nothing awaited: read_value %h status %b",
                   got.read_value, got.status);
            errors++;
            return;
         end
         want = awaited_replies.pop_front();
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %b, got %b", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   sprf_req_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   sprf_rsp_type rsp_word;

   access_scoreboard   sb = new();
   logic [ADDR_W-1:0]  written_keys [$];
   logic [ADDR_W-1:0]  hot_keys [48];
   bit                 quiet     = 1'b0;   // no idling on either side
   bit                 long_hold = 1'b0;   // request a long receiver hold-off
   int unsigned        idle_count;

   sparse_register_file #(.ENTRIES(SLOTS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Accepted words on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_access(req_word);
         if (rsp_valid && !rsp_stall) sb.check_reply(rsp_word);
      end
   end

   // Watchdog: cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= IDLE_LIMIT) begin
            $display("sparse_register_file: mismatch");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Mostly random words, with the extremes mixed in
   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] known_key();
      return written_keys[$urandom_range(0, written_keys.size() - 1)];
   endfunction

   // Offer one word after an optional gap; returns at the accepting edge
   task automatic send_access(input logic kind, input logic [ADDR_W-1:0] key,
                              input logic [DATA_W-1:0] data);
      sprf_req_type w;
      w.req_type    = kind;
      w.addr        = key;
      w.write_value = data;
      if (!quiet && !long_hold && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      if (kind == REQ_WRITE) written_keys.push_back(key);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait for every owed reply
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      logic              kind;
      logic [ADDR_W-1:0] key;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      rsp_stall <= 1'b0;
      hot_keys[0] = '0;
      hot_keys[1] = '1;
      hot_keys[2] = 32'h8000_0000;
      hot_keys[3] = 32'h0000_0001;
      hot_keys[4] = 32'h7FFF_FFFF;
      for (int k = 5; k < 48; k++) hot_keys[k] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: misses on an empty store, extremes, update in place,
      // near-miss keys, reads carrying garbage write data
      send_access(REQ_READ,  32'h0000_0000, 32'hFFFF_FFFF);
      send_access(REQ_READ,  32'hFFFF_FFFF, 32'h0000_0000);
      send_access(REQ_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_access(REQ_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_access(REQ_READ,  32'h0000_0000, 32'h1234_5678);
      send_access(REQ_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(REQ_READ,  32'h7FFF_FFFF, 32'h0000_0000);
      send_access(REQ_WRITE, 32'h0000_0000, 32'h5A5A_5A5A);
      send_access(REQ_READ,  32'h0000_0000, 32'h0000_0000);
      send_access(REQ_WRITE, 32'h8000_0000, 32'h8000_0001);
      send_access(REQ_READ,  32'h0000_0001, 32'hFFFF_FFFF);
      send_access(REQ_READ,  32'h8000_0000, 32'h0000_0000);
      send_access(REQ_WRITE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_access(REQ_WRITE, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
      send_access(REQ_READ,  32'hA5A5_A5A5, 32'h0000_0000);
      send_access(REQ_READ,  32'h5A5A_5A5A, 32'h0000_0000);
      send_access(REQ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(REQ_READ,  32'hFFFF_FFFF, 32'h0000_0000);
      send_access(REQ_READ,  32'hFFFF_FFFE, 32'h0000_0000);
      send_access(REQ_WRITE, 32'h8000_0000, 32'h0000_0000);
      send_access(REQ_READ,  32'h8000_0000, 32'hFFFF_FFFF);
      drain_replies();

      // Partly filled store: a small set of hot keys; starts under a long hold
      long_hold = 1'b1;
      for (int i = 0; i < 650; i++) begin
         kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
         key  = ($urandom_range(0, 9) == 0) ? random_word()
                                            : hot_keys[$urandom_range(0, 47)];
         send_access(kind, key, random_word());
      end
      drain_replies();

      // Filling: mostly writes of fresh keys until the store runs out
      for (int i = 0; i < 450; i++) begin
         if ($urandom_range(0, 99) < 65) begin
            key = ($urandom_range(0, 9) < 7) ? random_word() : known_key();
            send_access(REQ_WRITE, key, random_word());
         end else begin
            send_access(REQ_READ, known_key(), random_word());
         end
      end
      drain_replies();

      // Full store: updates, refused new keys, hits and near misses
      for (int i = 0; i < 700; i++) begin
         if (i == 500) quiet = 1'b1;
         kind = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
         case ($urandom_range(0, 3))
            0:       key = known_key() ^ (32'h1 << $urandom_range(0, 31));
            1:       key = random_word();
            default: key = known_key();
         endcase
         send_access(kind, key, random_word());
      end
      drain_replies();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("sparse_register_file: match");
      end else begin
         $display("sparse_register_file: mismatch");
      end
      $finish;
   end

endmodule

// ===== sparse_register_file.f =====
+incdir+design
design/sprf_pkg.sv
design/sprf_ram.sv
design/sprf_datapath.sv
design/sprf_ctrl.sv
design/sparse_register_file.sv
tb/sparse_register_file_tb.sv
